// ----- rtl/assert_macros.svh -----
// assertion helpers used by rtcprr_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked while out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/rtcprr_pkg.sv -----
`timescale 1ns / 1ps

package rtcprr_pkg;

	// configuration register indexes
	localparam logic CFG_OWN_SSRC    = 1'b0;
	localparam logic CFG_INACT_LIMIT = 1'b1;

	localparam logic [7:0] INACT_LIMIT_RESET = 8'd5;

	localparam logic KIND_RR  = 1'b0;
	localparam logic KIND_BYE = 1'b1;

	localparam logic [7:0]  FRAC_MAX = 8'hFF;
	localparam logic [23:0] CUM_MAX  = 24'h7FFFFF;
	localparam logic [23:0] CUM_MIN  = 24'h800000;

	// width of the shared subtractor
	localparam int ALU_W = 34;

	typedef struct packed {
		logic [31:0] packets_received;
		logic [31:0] extended_highest;
		logic [31:0] base_seq;
		logic [31:0] interarrival_jitter;
		logic [31:0] source_id;
		logic [31:0] last_sr_stamp;
		logic [31:0] delay;
	} item_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] reporter_id;
		logic [31:0] reported_id;
		logic [7:0]  fraction_lost;
		logic [23:0] cumulative_lost;
		logic [31:0] extended_highest;
		logic [31:0] jitter_out;
		logic [31:0] last_sr_stamp;
		logic [31:0] delay_out;
	} result_t;

	function automatic logic [ALU_W-1:0] sext32(input logic [31:0] v);
		sext32 = {{(ALU_W-32){v[31]}}, v};
	endfunction

	function automatic logic [ALU_W-1:0] zext32(input logic [31:0] v);
		zext32 = {{(ALU_W-32){1'b0}}, v};
	endfunction

endpackage

// ----- rtl/rtcprr_core.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtcprr_core
	import rtcprr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  item_t       item,
	input  logic [31:0] own_ssrc,
	input  logic [7:0]  inact_limit,
	output logic        in_ready,
	output logic        res_valid,
	input  logic        res_ready,
	output result_t     res
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CHK  = 4'd1;
	localparam logic [3:0] ST_EXP  = 4'd2;
	localparam logic [3:0] ST_CYE  = 4'd3;
	localparam logic [3:0] ST_CYR  = 4'd4;
	localparam logic [3:0] ST_LOST = 4'd5;
	localparam logic [3:0] ST_CUM  = 4'd6;
	localparam logic [3:0] ST_CMP  = 4'd7;
	localparam logic [3:0] ST_DIV  = 4'd8;
	localparam logic [3:0] ST_WAIT = 4'd9;

	logic [3:0]       state_q;
	item_t            item_q;
	logic [31:0]      exp_prior_q;
	logic [31:0]      recv_prior_q;
	logic [7:0]       inact_q;
	logic             halted_q;
	logic [31:0]      cum_exp_q;
	logic [31:0]      cyc_exp_q;
	logic [31:0]      cyc_recv_q;
	logic [ALU_W-1:0] lost_q;
	logic [23:0]      cum_lost_q;
	logic [31:0]      rem_q;
	logic [7:0]       frac_q;
	logic [2:0]       step_q;
	logic             kind_q;
	logic             res_valid_q;
	result_t          res_q;

	logic [ALU_W-1:0] alu_a;
	logic [ALU_W-1:0] alu_b;
	logic             alu_inc;
	logic [ALU_W-1:0] alu_res;
	logic [7:0]       inact_next;
	logic             exp_pos;
	logic             lost_pos;
	logic             out_free;
	result_t          res_next;

	// the one shared subtractor
	assign alu_res = alu_a - alu_b + {{(ALU_W-1){1'b0}}, alu_inc};

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_inc = 1'b0;
		case (state_q)
			ST_CHK, ST_CYR: begin
				alu_a = zext32(item_q.packets_received);
				alu_b = zext32(recv_prior_q);
			end
			ST_EXP: begin
				alu_a   = zext32(item_q.extended_highest);
				alu_b   = zext32(item_q.base_seq);
				alu_inc = 1'b1;
			end
			ST_CYE: begin
				alu_a = zext32(cum_exp_q);
				alu_b = zext32(exp_prior_q);
			end
			ST_LOST: begin
				alu_a = sext32(cyc_exp_q);
				alu_b = sext32(cyc_recv_q);
			end
			ST_CUM: begin
				alu_a = zext32(cum_exp_q);
				alu_b = zext32(item_q.packets_received);
			end
			ST_CMP: begin
				alu_a = lost_q;
				alu_b = sext32(cyc_exp_q);
			end
			ST_DIV: begin
				alu_a = {{(ALU_W-33){1'b0}}, rem_q, 1'b0};
				alu_b = zext32(cyc_exp_q);
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_inc = 1'b0;
			end
		endcase
	end

	assign inact_next = inact_q + 8'd1;
	assign exp_pos    = !cyc_exp_q[31] && (cyc_exp_q != 32'd0);
	assign lost_pos   = !lost_q[ALU_W-1] && (lost_q != '0);
	assign out_free   = !res_valid_q || res_ready;

	always_comb begin
		res_next             = '0;
		res_next.result_kind = kind_q;
		res_next.reporter_id = own_ssrc;
		res_next.reported_id = item_q.source_id;
		if (kind_q == KIND_RR) begin
			res_next.fraction_lost    = frac_q;
			res_next.cumulative_lost  = cum_lost_q;
			res_next.extended_highest = item_q.extended_highest;
			res_next.jitter_out       = item_q.interarrival_jitter;
			res_next.last_sr_stamp    = item_q.last_sr_stamp;
			res_next.delay_out        = item_q.delay;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= item;
		end
		case (state_q)
			ST_EXP:  cum_exp_q  <= alu_res[31:0];
			ST_CYE:  cyc_exp_q  <= alu_res[31:0];
			ST_CYR:  cyc_recv_q <= alu_res[31:0];
			ST_LOST: lost_q     <= alu_res;
			ST_CUM: begin
				if (!alu_res[31] && (alu_res[30:23] != 8'd0)) begin
					cum_lost_q <= CUM_MAX;
				end else if (alu_res[31] && (alu_res[30:23] != 8'hFF)) begin
					cum_lost_q <= CUM_MIN;
				end else begin
					cum_lost_q <= alu_res[23:0];
				end
			end
			ST_CMP: begin
				rem_q  <= lost_q[31:0];
				frac_q <= (exp_pos && lost_pos && !alu_res[ALU_W-1]) ? FRAC_MAX : 8'd0;
			end
			ST_DIV: begin
				if (!alu_res[ALU_W-1]) begin
					rem_q  <= alu_res[31:0];
					frac_q <= {frac_q[6:0], 1'b1};
				end else begin
					rem_q  <= {rem_q[30:0], 1'b0};
					frac_q <= {frac_q[6:0], 1'b0};
				end
			end
			default: ;
		endcase
		if (state_q == ST_WAIT && out_free) begin
			res_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			exp_prior_q  <= '0;
			recv_prior_q <= '0;
			inact_q      <= '0;
			halted_q     <= 1'b0;
			kind_q       <= KIND_RR;
			step_q       <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_WAIT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start && !halted_q) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (alu_res == '0) begin
						inact_q <= inact_next;
						if (inact_next == inact_limit) begin
							halted_q <= 1'b1;
							kind_q   <= KIND_BYE;
							state_q  <= ST_WAIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						kind_q  <= KIND_RR;
						state_q <= ST_EXP;
					end
				end
				ST_EXP:  state_q <= ST_CYE;
				ST_CYE:  state_q <= ST_CYR;
				ST_CYR:  state_q <= ST_LOST;
				ST_LOST: state_q <= ST_CUM;
				ST_CUM:  state_q <= ST_CMP;
				ST_CMP: begin
					step_q <= '0;
					if (exp_pos && lost_pos && alu_res[ALU_W-1]) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (kind_q == KIND_RR) begin
							exp_prior_q  <= cum_exp_q;
							recv_prior_q <= item_q.packets_received;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	`ASSERT_AT(a_halt_sticks, clk, arst_n, halted_q |=> halted_q, "halt flag cleared")
	`ASSERT_AT(a_div_bounds, clk, arst_n, (state_q == ST_DIV) |-> (!cyc_exp_q[31] && (rem_q < cyc_exp_q)), "divide remainder out of range")
	`ASSERT_AT(a_bye_zero, clk, arst_n, (res_valid_q && res_q.result_kind) |-> ((res_q.fraction_lost == 8'd0) && (res_q.cumulative_lost == 24'd0) && (res_q.delay_out == 32'd0)), "bye beat carries report fields")
	`ASSERT_AT(a_no_work_halted, clk, arst_n, ($past(halted_q) && ($past(state_q) == ST_IDLE)) |-> (state_q == ST_IDLE), "work started after halt")

endmodule

// ----- rtl/rtcp_receiver_report_stats.sv -----
`timescale 1ns / 1ps

// Builds one RTCP receiver report per report tick from the receiver's counters, or, on the
// inactivity_limit-th tick since reset with no new packets, a single bye beat, after which
// the block stays halted until reset and swallows further ticks. One 34-bit subtractor is
// shared by a small sequencer that walks a report from the accepted beat to the result
// register, adding an 8-step restoring divide when the loss fraction needs it.
// s_tready is high only while the sequencer is idle; a finished result waits in the output
// register and the sequencer holds until that register is free.

module rtcp_receiver_report_stats
	import rtcprr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// packets_received, highest_seq, seq_cycles, base_seq, interarrival_jitter,
	// source_id, sr_ntp_high, sr_ntp_low, since_sr_delay
	input  logic [255:0] s_tdata,
	// sr_seen
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// reporter_id, reported_id, fraction_lost, cumulative_lost, extended_highest,
	// jitter_out, last_sr_stamp, delay_out
	output logic [223:0] m_tdata,
	// result_kind
	output logic         m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);

	logic [31:0] own_ssrc_q;
	logic [7:0]  inact_limit_q;
	item_t       item;
	result_t     res;
	logic        start;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ssrc_q    <= '0;
			inact_limit_q <= INACT_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OWN_SSRC:    own_ssrc_q    <= cfg_data;
				CFG_INACT_LIMIT: inact_limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// unpack the input beat
	always_comb begin
		item.packets_received    = s_tdata[31:0];
		item.extended_highest    = {s_tdata[63:48], s_tdata[47:32]};
		item.base_seq            = s_tdata[95:64];
		item.interarrival_jitter = s_tdata[127:96];
		item.source_id           = s_tdata[159:128];
		item.last_sr_stamp       = {s_tdata[175:160], s_tdata[223:208]};
		item.delay               = s_tuser ? s_tdata[255:224] : 32'd0;
	end

	assign start = s_tvalid && s_tready;

	rtcprr_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.item        (item),
		.own_ssrc    (own_ssrc_q),
		.inact_limit (inact_limit_q),
		.in_ready    (s_tready),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res         (res)
	);

	assign m_tdata = {res.delay_out, res.last_sr_stamp, res.jitter_out, res.extended_highest,
		res.cumulative_lost, res.fraction_lost, res.reported_id, res.reporter_id};
	assign m_tuser = res.result_kind;

endmodule

// ----- test/rtcp_receiver_report_stats_tb.sv -----
`timescale 1ns / 1ps

module rtcp_receiver_report_stats_tb;
	import rtcprr_pkg::*;

	typedef struct packed {
		logic        sr_seen;
		logic [31:0] since_sr_delay;
		logic [31:0] sr_ntp_low;
		logic [31:0] sr_ntp_high;
		logic [31:0] source_id;
		logic [31:0] jitter;
		logic [31:0] base_seq;
		logic [15:0] seq_cycles;
		logic [15:0] highest_seq;
		logic [31:0] packets;
	} tick_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// packets_received, highest_seq, seq_cycles, base_seq, interarrival_jitter,
	// source_id, sr_ntp_high, sr_ntp_low, since_sr_delay
	logic [255:0] s_tdata;
	// sr_seen
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// reporter_id, reported_id, fraction_lost, cumulative_lost, extended_highest,
	// jitter_out, last_sr_stamp, delay_out
	logic [223:0] m_tdata;
	// result_kind
	logic         m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [31:0]  cfg_data;

	logic [31:0] own_ssrc_q    = '0;
	logic [7:0]  inact_limit_q = INACT_LIMIT_RESET;
	logic [31:0] exp_prior     = '0;
	logic [31:0] rx_prior      = '0;
	logic [7:0]  inact_cnt     = '0;
	bit          halted_q      = 1'b0;

	result_t     pending_reports[$];
	int          errors        = 0;
	int          idle_pct      = 33;
	bit          bye_armed     = 1'b0;
	logic [31:0] session_base;
	logic [31:0] session_src;

	rtcp_receiver_report_stats u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic bit predict_report(input tick_t t, output result_t r);
		logic [31:0] ext;
		logic [31:0] cum_exp;
		int          d_exp;
		int          d_rx;
		int          cum32;
		longint      lost;
		longint      q;
		r = '0;
		if (halted_q)
			return 1'b0;
		if (t.packets == rx_prior) begin
			inact_cnt = inact_cnt + 8'd1;
			if (inact_cnt != inact_limit_q)
				return 1'b0;
			halted_q = 1'b1;
			r.result_kind = KIND_BYE;
			r.reporter_id = own_ssrc_q;
			r.reported_id = t.source_id;
			return 1'b1;
		end
		ext = {t.seq_cycles, t.highest_seq};
		cum_exp = ext - t.base_seq + 32'd1;
		d_exp = cum_exp - exp_prior;
		d_rx = t.packets - rx_prior;
		lost = longint'(d_exp) - longint'(d_rx);
		if (d_exp > 0 && lost > 0) begin
			q = (lost * 256) / d_exp;
			r.fraction_lost = (q > 255) ? FRAC_MAX : q[7:0];
		end
		cum32 = cum_exp - t.packets;
		if (cum32 > 8388607)
			r.cumulative_lost = CUM_MAX;
		else if (cum32 < -8388608)
			r.cumulative_lost = CUM_MIN;
		else
			r.cumulative_lost = cum32[23:0];
		r.result_kind = KIND_RR;
		r.reporter_id = own_ssrc_q;
		r.reported_id = t.source_id;
		r.extended_highest = ext;
		r.jitter_out = t.jitter;
		r.last_sr_stamp = {t.sr_ntp_high[15:0], t.sr_ntp_low[31:16]};
		r.delay_out = t.sr_seen ? t.since_sr_delay : 32'd0;
		exp_prior = cum_exp;
		rx_prior = t.packets;
		return 1'b1;
	endfunction

	function automatic tick_t make_tick(input logic [31:0] cum_exp, input logic [31:0] pkts);
		tick_t       t;
		logic [31:0] ext;
		ext = cum_exp + session_base - 32'd1;
		t.packets = pkts;
		t.highest_seq = ext[15:0];
		t.seq_cycles = ext[31:16];
		t.base_seq = session_base;
		t.jitter = ($urandom_range(3) == 0) ? $urandom : $urandom_range(5000);
		t.source_id = session_src;
		t.sr_ntp_high = $urandom;
		t.sr_ntp_low = $urandom;
		t.sr_seen = 1'($urandom_range(1));
		t.since_sr_delay = $urandom;
		return t;
	endfunction

	function automatic tick_t noise_tick();
		tick_t t;
		for (int i = 0; i < 8; i++)
			t[i*32 +: 32] = $urandom;
		t.sr_seen = 1'($urandom_range(1));
		return t;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 10)
				$display("mismatch %s: expected %h, got %h", name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.result_kind = m_tuser;
			got.reporter_id = m_tdata[31:0];
			got.reported_id = m_tdata[63:32];
			got.fraction_lost = m_tdata[71:64];
			got.cumulative_lost = m_tdata[95:72];
			got.extended_highest = m_tdata[127:96];
			got.jitter_out = m_tdata[159:128];
			got.last_sr_stamp = m_tdata[191:160];
			got.delay_out = m_tdata[223:192];
			if (pending_reports.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result beat with nothing expected: kind %0d, data %h",
						got.result_kind, m_tdata);
			end else begin
				want = pending_reports.pop_front();
				check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
				check_field("reporter_id", want.reporter_id, got.reporter_id);
				check_field("reported_id", want.reported_id, got.reported_id);
				check_field("fraction_lost", 32'(want.fraction_lost),
					32'(got.fraction_lost));
				check_field("cumulative_lost", 32'(want.cumulative_lost),
					32'(got.cumulative_lost));
				check_field("extended_highest", want.extended_highest, got.extended_highest);
				check_field("jitter_out", want.jitter_out, got.jitter_out);
				check_field("last_sr_stamp", want.last_sr_stamp, got.last_sr_stamp);
				check_field("delay_out", want.delay_out, got.delay_out);
			end
		end
		m_tready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
	end

	task automatic send_tick(input tick_t t);
		result_t r;
		// keep the bye for the last test, the block halts for good after it
		if (!bye_armed && !halted_q && t.packets == rx_prior && inact_cnt + 8'd1 == inact_limit_q)
			t.packets = t.packets + 32'd1;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= t[255:0];
		s_tuser <= t.sr_seen;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (predict_report(t, r))
			pending_reports.push_back(r);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_OWN_SSRC)
			own_ssrc_q = val;
		else
			inact_limit_q = val[7:0];
	endtask

	task automatic test_reset_defaults();
		send_tick('0);
		send_tick(make_tick(32'd10, 32'd10));
		send_tick(make_tick(32'd12, 32'd10));
		send_tick('1);
	endtask

	task automatic test_config_extremes();
		write_reg(CFG_OWN_SSRC, 32'hFFFF_FFFF);
		write_reg(CFG_INACT_LIMIT, 32'd255);
	endtask

	task automatic test_loss_and_saturation();
		tick_t t;
		session_base = 32'hFFFF_FF00;
		session_src = $urandom;
		send_tick(make_tick(exp_prior + 32'd300, rx_prior + 32'd290));
		// interval expected negative, then zero
		send_tick(make_tick(exp_prior - 32'd5, rx_prior + 32'd3));
		send_tick(make_tick(exp_prior, rx_prior + 32'd2));
		// nothing lost, then duplicates
		send_tick(make_tick(exp_prior + 32'd50, rx_prior + 32'd50));
		send_tick(make_tick(exp_prior + 32'd50, rx_prior + 32'd60));
		send_tick(make_tick(exp_prior + 32'd256, rx_prior + 32'd200));
		send_tick(make_tick(exp_prior + 32'd256, rx_prior + 32'd1));
		// count going backward pushes the fraction past full scale
		send_tick(make_tick(exp_prior + 32'd10, rx_prior - 32'd5));
		send_tick(make_tick(exp_prior + 32'h7FFF_FFFF, rx_prior + 32'd1));
		send_tick(make_tick(rx_prior + 32'd1 + 32'h007F_FFFF, rx_prior + 32'd1));
		send_tick(make_tick(rx_prior + 32'd1 + 32'h0080_0000, rx_prior + 32'd1));
		send_tick(make_tick(rx_prior + 32'd1 - 32'h0080_0000, rx_prior + 32'd1));
		send_tick(make_tick(rx_prior + 32'd1 - 32'h0080_0001, rx_prior + 32'd1));
		send_tick(make_tick(rx_prior + 32'd1 + 32'h8000_0000, rx_prior + 32'd1));
		send_tick(make_tick(exp_prior + 32'd2, rx_prior));
		t = make_tick(exp_prior + 32'd40, rx_prior + 32'd40);
		t.sr_seen = 1'b0;
		t.since_sr_delay = 32'hFFFF_FFFF;
		send_tick(t);
		t = make_tick(exp_prior + 32'd40, rx_prior + 32'd39);
		t.sr_seen = 1'b1;
		send_tick(t);
		send_tick(noise_tick());
	endtask

	task automatic run_random(input int n);
		tick_t       t;
		int          pick;
		logic [31:0] d_exp;
		logic [31:0] d_rx;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 2) begin
				session_base = $urandom;
				session_src = $urandom;
			end
			if (pick < 70) begin
				d_exp = ($urandom_range(19) == 0) ? $urandom : $urandom_range(400);
				d_rx = d_exp - (($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(3));
				if ($urandom_range(15) == 0)
					d_rx = d_exp + $urandom_range(5);
				t = make_tick(exp_prior + d_exp, rx_prior + d_rx);
			end else if (pick < 85) begin
				t = make_tick(exp_prior + $urandom_range(3), rx_prior);
			end else begin
				t = noise_tick();
			end
			send_tick(t);
			if ($urandom_range(199) == 0)
				wait_drained();
		end
	endtask

	task automatic test_random_traffic();
		session_base = $urandom;
		session_src = $urandom;
		write_reg(CFG_OWN_SSRC, 32'd0);
		write_reg(CFG_INACT_LIMIT, 32'd1);
		run_random(460);
		write_reg(CFG_OWN_SSRC, $urandom);
		write_reg(CFG_INACT_LIMIT, 32'd255);
		run_random(460);
		write_reg(CFG_OWN_SSRC, $urandom);
		write_reg(CFG_INACT_LIMIT, $urandom_range(255, 1));
		idle_pct = 0;
		run_random(460);
		idle_pct = 33;
		write_reg(CFG_OWN_SSRC, $urandom);
		write_reg(CFG_INACT_LIMIT, $urandom_range(255, 1));
		run_random(460);
	endtask

	task automatic test_bye_and_halt();
		logic [7:0] lim;
		write_reg(CFG_OWN_SSRC, $urandom);
		// limit under the current count where possible, so the counter has to wrap first
		lim = (inact_cnt > 8'd1) ? inact_cnt - 8'd1 : 8'd200;
		write_reg(CFG_INACT_LIMIT, {24'd0, lim});
		bye_armed = 1'b1;
		while (!halted_q)
			send_tick(make_tick(exp_prior + $urandom_range(3), rx_prior));
		repeat (4) begin
			send_tick(make_tick(exp_prior + 32'd20, rx_prior + 32'd18));
			send_tick(make_tick(exp_prior, rx_prior));
			send_tick(noise_tick());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_OWN_SSRC;
		cfg_data <= '0;
		session_base = $urandom;
		session_src = $urandom;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_config_extremes();
		test_loss_and_saturation();
		test_random_traffic();
		test_bye_and_halt();

		wait_drained();
		if (errors == 0 && pending_reports.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
